// ----- hdl/eida_pkg.sv -----
// Package: shared constants, types and codes of the extent ID allocator.
`timescale 1ns / 1ps
package eida_pkg;

  localparam int NUM_EXT    = 16;
  localparam int IDX_W      = $clog2(NUM_EXT);
  localparam int CNT_W      = $clog2(NUM_EXT + 1);
  localparam int NUM_PIECES = 16;
  localparam int PIECE_W    = $clog2(NUM_PIECES);
  localparam int ID_W       = 64;

  localparam logic [ID_W-1:0] RESET_BASE  = 64'h0000_0000_0010_0000;
  localparam logic [ID_W-1:0] RESET_TOTAL = 64'hffff_ffff_ffff_feff;
  // Default extent length, cut so the extent ends below the top of ID space
  localparam logic [ID_W-1:0] RESET_LEN   =
    (RESET_TOTAL > ~RESET_BASE) ? ~RESET_BASE : RESET_TOTAL;

  // Configuration register indexes
  localparam logic CFG_BASE_ID   = 1'b0;
  localparam logic CFG_TOTAL_IDS = 1'b1;

  // Request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NONE_FREE = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_OVERLAP   = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_SCAN,
    S_COMMIT
  } eida_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic alloc;
    logic scan;
    logic commit;
  } eida_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_free;
    logic imm_done;
    logic alloc_last;
    logic scan_stop;
  } eida_sts_t;

endpackage

// ----- hdl/eida_ctrl.sv -----
// Controller: sequences allocate pieces and the free scan and commit.
`timescale 1ns / 1ps
module eida_ctrl import eida_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  eida_sts_t sts,
  output eida_cmd_t cmd
);

  eida_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (!sts.imm_done) begin
            state_nxt = sts.req_free ? S_SCAN : S_ALLOC;
          end
        end
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        if (sts.alloc_last) state_nxt = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_stop) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/eida_dp.sv -----
// Datapath: extent table, request registers and result registers.
`timescale 1ns / 1ps
module eida_dp import eida_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  eida_cmd_t       cmd,
  output eida_sts_t       sts,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [ID_W-1:0] cfg_data,
  input  logic            in_req_type,
  input  logic [ID_W-1:0] in_start_id,
  input  logic [ID_W-1:0] in_count,
  output logic            out_valid,
  output logic [ID_W-1:0] out_first_id,
  output logic [ID_W-1:0] out_granted_count,
  output logic [1:0]      out_status,
  output logic            out_last
);

  logic [ID_W-1:0]    first_r [NUM_EXT];
  logic [ID_W-1:0]    first_nxt [NUM_EXT];
  logic [ID_W-1:0]    len_r [NUM_EXT];
  logic [ID_W-1:0]    len_nxt [NUM_EXT];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ID_W-1:0]    base_r, base_nxt, total_r, total_nxt;
  logic [ID_W-1:0]    s_r, s_nxt, c_r, c_nxt, end_r, end_nxt;
  logic [PIECE_W-1:0] piece_r, piece_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [ID_W-1:0]    pf_r, pf_nxt, pl_r, pl_nxt, nf_r, nf_nxt, nl_r, nl_nxt;
  logic               ov_r, ov_nxt;
  logic [ID_W-1:0]    of_r, of_nxt, og_r, og_nxt;
  logic [1:0]         os_r, os_nxt;
  logic               ol_r, ol_nxt;

  logic [ID_W-1:0]    take, rem, rd_first, rd_len, nb, nt, ilen, prev_end;
  logic               take_all, scan_go, has_prev, has_next, overlap, jp, jn;
  logic [CNT_W-1:0]   new_cnt, jj;
  logic [IDX_W-1:0]   pm1;

  assign rd_first = first_r[idx_r[IDX_W-1:0]];
  assign rd_len   = len_r[idx_r[IDX_W-1:0]];
  assign take     = (len_r[0] < c_r) ? len_r[0] : c_r;
  assign rem      = c_r - take;
  assign take_all = (take == len_r[0]);
  assign new_cnt  = take_all ? cnt_r - CNT_W'(1) : cnt_r;
  assign scan_go  = (idx_r < cnt_r) && (rd_first < s_r);
  assign has_prev = (idx_r != '0);
  assign has_next = (idx_r < cnt_r);
  assign prev_end = pf_r + pl_r;
  assign overlap  = (has_prev && prev_end > s_r) || (has_next && nf_r < end_r);
  assign jp       = has_prev && (prev_end == s_r);
  assign jn       = has_next && (nf_r == end_r);
  assign pm1      = IDX_W'(idx_r - CNT_W'(1));

  // Status to controller
  always_comb begin
    sts.req_free   = (in_req_type == REQ_FREE);
    sts.imm_done   = (in_count == '0) ||
                     ((in_req_type == REQ_ALLOC) && (cnt_r == '0)) ||
                     ((in_req_type == REQ_FREE) && (in_count > ~in_start_id));
    sts.alloc_last = (rem == '0) || (new_cnt == '0) ||
                     (piece_r == PIECE_W'(NUM_PIECES - 1));
    sts.scan_stop  = !scan_go;
  end

  // Next state of table, request and results
  always_comb begin
    first_nxt = first_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    base_nxt  = base_r;
    total_nxt = total_r;
    s_nxt = s_r; c_nxt = c_r; end_nxt = end_r;
    piece_nxt = piece_r; idx_nxt = idx_r;
    pf_nxt = pf_r; pl_nxt = pl_r; nf_nxt = nf_r; nl_nxt = nl_r;
    ov_nxt = 1'b0;
    of_nxt = '0; og_nxt = '0; os_nxt = ST_OK; ol_nxt = 1'b1;
    nb = base_r; nt = total_r; ilen = '0; jj = '0;

    // Configuration write reloads the initial extent
    if (cfg_we) begin
      if (cfg_index == CFG_BASE_ID) nb = cfg_data;
      else nt = cfg_data;
      ilen         = (nt > ~nb) ? ~nb : nt;
      base_nxt     = nb;
      total_nxt    = nt;
      first_nxt[0] = nb;
      len_nxt[0]   = ilen;
      cnt_nxt      = (ilen == '0) ? CNT_W'(0) : CNT_W'(1);
    end

    // Request accept, immediate results
    if (cmd.accept) begin
      s_nxt     = in_start_id;
      c_nxt     = in_count;
      end_nxt   = in_start_id + in_count;
      piece_nxt = '0;
      idx_nxt   = '0;
      if (sts.imm_done) begin
        ov_nxt = 1'b1;
        if (in_count != '0) begin
          os_nxt = (in_req_type == REQ_FREE) ? ST_OVERLAP : ST_NONE_FREE;
        end
      end
    end

    // One piece from the lowest extent
    if (cmd.alloc) begin
      ov_nxt    = 1'b1;
      of_nxt    = first_r[0];
      og_nxt    = take;
      ol_nxt    = sts.alloc_last;
      c_nxt     = rem;
      piece_nxt = piece_r + PIECE_W'(1);
      cnt_nxt   = new_cnt;
      if (take_all) begin
        for (int j = 0; j < NUM_EXT - 1; j++) begin
          first_nxt[j] = first_r[j+1];
          len_nxt[j]   = len_r[j+1];
        end
      end else begin
        first_nxt[0] = first_r[0] + take;
        len_nxt[0]   = len_r[0] - take;
      end
    end

    // Walk to the insert position
    if (cmd.scan) begin
      if (scan_go) begin
        pf_nxt  = rd_first;
        pl_nxt  = rd_len;
        idx_nxt = idx_r + CNT_W'(1);
      end else begin
        nf_nxt = rd_first;
        nl_nxt = rd_len;
      end
    end

    // Merge, insert or reject the freed run
    if (cmd.commit) begin
      ov_nxt = 1'b1;
      if (overlap) begin
        os_nxt = ST_OVERLAP;
      end else if (jp && jn) begin
        len_nxt[pm1] = pl_r + c_r + nl_r;
        for (int j = 0; j < NUM_EXT - 1; j++) begin
          jj = CNT_W'(j);
          if (jj >= idx_r) begin
            first_nxt[j] = first_r[j+1];
            len_nxt[j]   = len_r[j+1];
          end
        end
        cnt_nxt = cnt_r - CNT_W'(1);
      end else if (jp) begin
        len_nxt[pm1] = pl_r + c_r;
      end else if (jn) begin
        first_nxt[idx_r[IDX_W-1:0]] = s_r;
        len_nxt[idx_r[IDX_W-1:0]]   = nl_r + c_r;
      end else if (cnt_r >= CNT_W'(NUM_EXT)) begin
        os_nxt = ST_FULL;
      end else begin
        for (int j = 1; j < NUM_EXT; j++) begin
          jj = CNT_W'(j);
          if (jj > idx_r) begin
            first_nxt[j] = first_r[j-1];
            len_nxt[j]   = len_r[j-1];
          end
        end
        first_nxt[idx_r[IDX_W-1:0]] = s_r;
        len_nxt[idx_r[IDX_W-1:0]]   = c_r;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= CNT_W'(1);
      base_r  <= RESET_BASE;
      total_r <= RESET_TOTAL;
      ov_r    <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      base_r  <= base_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Table, with the initial extent loaded at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r[0] <= RESET_BASE;
      len_r[0]   <= RESET_LEN;
    end else begin
      first_r <= first_nxt;
      len_r   <= len_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s_r <= s_nxt; c_r <= c_nxt; end_r <= end_nxt;
    piece_r <= piece_nxt; idx_r <= idx_nxt;
    pf_r <= pf_nxt; pl_r <= pl_nxt; nf_r <= nf_nxt; nl_r <= nl_nxt;
    of_r <= of_nxt; og_r <= og_nxt; os_r <= os_nxt; ol_r <= ol_nxt;
  end

  assign out_valid         = ov_r;
  assign out_first_id      = of_r;
  assign out_granted_count = og_r;
  assign out_status        = os_r;
  assign out_last          = ol_r;

endmodule

// ----- hdl/extent_id_allocator_top.sv -----
// Top level of the extent ID allocator: controller plus datapath.
//
//  channel | handshake        | payload
//  input   | start / busy     | in_req_type, in_start_id, in_count
//  result  | out_valid strobe | out_first_id, out_granted_count, out_status, out_last
//  config  | cfg_we           | cfg_index, cfg_data
//
// Allocate: accept, then one result per piece (up to 16 pieces) from the lowest
// extent; a zero count, an allocate on an empty table or a free past the
// top of ID space answers right from the accept.
// Free: accept, then a scan past each extent that starts below the run and a
// stop step, then one commit that merges, inserts or rejects the run.
// Results are registered; the pieces of an allocate come one per cycle.
// Reset (synchronous, rst_n low) loads the default extent; the receiver cannot stall.
`timescale 1ns / 1ps
module extent_id_allocator_top import eida_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic            in_req_type,
  input  logic [ID_W-1:0] in_start_id,
  input  logic [ID_W-1:0] in_count,
  output logic            out_valid,
  output logic [ID_W-1:0] out_first_id,
  output logic [ID_W-1:0] out_granted_count,
  output logic [1:0]      out_status,
  output logic            out_last,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [ID_W-1:0] cfg_data
);

  eida_cmd_t cmd;
  eida_sts_t sts;

  eida_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  eida_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_req_type       (in_req_type),
    .in_start_id       (in_start_id),
    .in_count          (in_count),
    .out_valid         (out_valid),
    .out_first_id      (out_first_id),
    .out_granted_count (out_granted_count),
    .out_status        (out_status),
    .out_last          (out_last)
  );

endmodule

// ----- hdl/eida_checker.sv -----
// Checker: port-level properties of the allocator, bound to the top level.
`timescale 1ns / 1ps
module eida_checker import eida_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic [ID_W-1:0] in_count,
  input logic            out_valid,
  input logic [ID_W-1:0] out_first_id,
  input logic [ID_W-1:0] out_granted_count,
  input logic [1:0]      out_status,
  input logic            out_last
);

  // Zero-count request answers on the next cycle with a final ok
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_count == '0) |=>
      (out_valid && out_last && out_status == ST_OK))
    else $error("zero-count request not answered at once");

  // Allocate pieces come back to back until the last one
  a_pieces: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a multi-piece result");

  // Any error status ends the request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_last)
    else $error("error result not marked last");

  // Nothing granted means no first ID
  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted_count == '0) |-> (out_first_id == '0))
    else $error("first ID without a grant");

  // Free requests give one result only
  a_free_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted_count == '0 && out_status == ST_OK) |-> out_last)
    else $error("empty ok result not last");

endmodule

bind extent_id_allocator_top eida_checker u_eida_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_count          (in_count),
  .out_valid         (out_valid),
  .out_first_id      (out_first_id),
  .out_granted_count (out_granted_count),
  .out_status        (out_status),
  .out_last          (out_last)
);
